/* hdl/ids_pkg.sv */
package ids_pkg;

  localparam int unsigned IdsFractionBits = 16;
  localparam int unsigned IdsOutFracBits  = 15;
  localparam int unsigned IdsCordicStages = 16;
  localparam int unsigned IdsSqrtSteps    = IdsOutFracBits + 1;
  localparam int unsigned IdsOutW         = IdsOutFracBits + 1;
  localparam int unsigned IdsCordicFrac   = 30;

  localparam logic signed [31:0] IdsCordicGain = 32'sd652032874;

  // Item moving through the square-root cells.
  typedef struct packed {
    logic [31:0]        rem;
    logic [31:0]        root;
    logic signed [31:0] ang;
    logic [1:0]         quad;
    logic signed [15:0] mu;
  } ids_sq_t;

  // Item moving through the rotation cells.
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] ang;
    logic [1:0]         quad;
    logic signed [15:0] mu;
    logic [15:0]        wt;
  } ids_cr_t;

  // Arctangent of 2^-i in binary angle units, 2^32 per turn.
  function automatic logic [31:0] ids_atan(input int unsigned i);
    logic [31:0] a;
    case (i)
      0:  a = 32'h20000000;  1:  a = 32'h12E4051E;  2:  a = 32'h09FB385B;
      3:  a = 32'h051111D4;  4:  a = 32'h028B0D43;  5:  a = 32'h0145D7E1;
      6:  a = 32'h00A2F61E;  7:  a = 32'h00517C55;  8:  a = 32'h0028BE53;
      9:  a = 32'h00145F2F;  10: a = 32'h000A2F98;  11: a = 32'h000517CC;
      12: a = 32'h00028BE6;  13: a = 32'h000145F3;  14: a = 32'h0000A2FA;
      15: a = 32'h0000517D;  16: a = 32'h000028BE;  17: a = 32'h0000145F;
      18: a = 32'h00000A30;  19: a = 32'h00000518;  20: a = 32'h0000028C;
      21: a = 32'h00000146;  22: a = 32'h000000A3;  23: a = 32'h00000051;
      24: a = 32'h00000029;  25: a = 32'h00000014;  26: a = 32'h0000000A;
      27: a = 32'h00000005;  28: a = 32'h00000003;  29: a = 32'h00000001;
      30: a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

/* hdl/ids_in_if.sv */
interface ids_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] polar_fraction;
  logic [15:0] azimuth_fraction;

  modport source (output valid, output polar_fraction, output azimuth_fraction, input ready);
  modport sink (input valid, input polar_fraction, input azimuth_fraction, output ready);
endinterface

/* hdl/ids_out_if.sv */
interface ids_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] dir_x;
  logic signed [15:0] dir_y;
  logic signed [15:0] dir_z;

  modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
  modport sink (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

/* hdl/ids_sqrt_cell.sv */
module ids_sqrt_cell import ids_pkg::*; #(
  parameter int unsigned Step = 0
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    en_i,
  input  logic    vld_i,
  input  ids_sq_t dat_i,
  output logic    vld_o,
  output ids_sq_t dat_o
);

  localparam logic [31:0] Bit = 32'd1 << (2 * (IdsSqrtSteps - 1 - Step));

  logic    vld_q;
  ids_sq_t dat_q, dat_d;
  logic [31:0] trial;

  // One restoring digit of the integer square root.
  always_comb begin
    trial = dat_i.root + Bit;
    dat_d = dat_i;
    if (dat_i.rem >= trial) begin
      dat_d.rem  = dat_i.rem - trial;
      dat_d.root = (dat_i.root >> 1) + Bit;
    end else begin
      dat_d.root = dat_i.root >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dat_q <= dat_d;
    end
  end

  assign vld_o = vld_q;
  assign dat_o = dat_q;

endmodule

/* hdl/ids_cordic_cell.sv */
module ids_cordic_cell import ids_pkg::*; #(
  parameter int unsigned Stage = 0
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    en_i,
  input  logic    vld_i,
  input  ids_cr_t dat_i,
  output logic    vld_o,
  output ids_cr_t dat_o
);

  localparam logic signed [31:0] Atan = $signed(ids_atan(Stage));

  logic    vld_q;
  ids_cr_t dat_q, dat_d;
  logic signed [31:0] dx, dy;

  // One micro-rotation toward zero residual angle.
  always_comb begin
    dx    = dat_i.y >>> Stage;
    dy    = dat_i.x >>> Stage;
    dat_d = dat_i;
    if (!dat_i.ang[31]) begin
      dat_d.x   = dat_i.x - dx;
      dat_d.y   = dat_i.y + dy;
      dat_d.ang = dat_i.ang - Atan;
    end else begin
      dat_d.x   = dat_i.x + dx;
      dat_d.y   = dat_i.y - dy;
      dat_d.ang = dat_i.ang + Atan;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dat_q <= dat_d;
    end
  end

  assign vld_o = vld_q;
  assign dat_o = dat_q;

endmodule

/* hdl/isotropic_direction_sampler.sv */
// Isotropic direction sampler.
// Input channel in_i carries two uniform 16-bit fractions per beat: the
// polar fraction sets the polar cosine mu = 2*u1 - 1, and the azimuth
// fraction is a fraction of a full turn. Output channel out_o carries one
// unit vector per input beat as signed Q1.15 components; dir_z is mu, and
// a component of +1.0 saturates to the largest code.
// The datapath is one stall-able pipeline: an input stage, one cell per
// square-root digit (16 cells), one cell per CORDIC stage, a multiply
// stage and the output register.
// Throughput is one beat per cycle unless out_o stalls; the chain of cells
// sets that figure, since every cell passes its item on each advance.
// When the receiver holds ready low while a result waits, the whole chain
// freezes and in_i.ready drops; nothing is lost or duplicated.
// Reset clears every valid flag, so no beat leaves the block until a new
// input beat has gone through the chain.
module isotropic_direction_sampler import ids_pkg::*; #(
  parameter int unsigned CORDIC_STAGES = IdsCordicStages
) (
  input  logic clk_i,
  input  logic rst_ni,
  ids_in_if.sink    in_i,
  ids_out_if.source out_o
);

  // Global advance: the chain moves whenever the output slot is free or
  // is being emptied in this cycle.
  logic adv;
  logic out_vld_q;
  assign adv      = !out_vld_q || out_o.ready;
  assign in_i.ready = adv;

  // Input stage: polar cosine, radicand for the sine weight, and the
  // azimuth folded into one quadrant with a residual of at most 1/8 turn.
  logic signed [15:0] mu;
  logic signed [31:0] mu_w;
  logic [31:0]        mu_sq;
  logic [15:0]        az_shift, az_res;
  logic [1:0]         quad;
  ids_sq_t            sq_in;

  always_comb begin
    mu       = $signed({~in_i.polar_fraction[15], in_i.polar_fraction[14:0]});
    mu_w     = 32'(mu);
    mu_sq    = 32'(mu_w * mu_w);
    az_shift = in_i.azimuth_fraction + 16'h2000;
    quad     = az_shift[15:14];
    az_res   = in_i.azimuth_fraction - {quad, 14'd0};
    sq_in.rem  = (32'd1 << (2 * IdsOutFracBits)) - mu_sq;
    sq_in.root = '0;
    sq_in.ang  = $signed({az_res, 16'd0});
    sq_in.quad = quad;
    sq_in.mu   = mu;
  end

  logic    in_vld_q;
  ids_sq_t in_dat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (adv) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_dat_q <= sq_in;
    end
  end

  // Square-root cells: one result bit of the sine weight per cell.
  logic    sq_vld [IdsSqrtSteps+1];
  ids_sq_t sq_dat [IdsSqrtSteps+1];
  assign sq_vld[0] = in_vld_q;
  assign sq_dat[0] = in_dat_q;

  for (genvar k = 0; k < IdsSqrtSteps; k++) begin : g_sqrt
    ids_sqrt_cell #(.Step(k)) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (adv),
      .vld_i (sq_vld[k]),
      .dat_i (sq_dat[k]),
      .vld_o (sq_vld[k+1]),
      .dat_o (sq_dat[k+1])
    );
  end

  // Rotation cells, started from the gain-compensated unit vector.
  logic    cr_vld [CORDIC_STAGES+1];
  ids_cr_t cr_dat [CORDIC_STAGES+1];
  ids_cr_t cr_first;

  always_comb begin
    cr_first.x    = IdsCordicGain;
    cr_first.y    = '0;
    cr_first.ang  = sq_dat[IdsSqrtSteps].ang;
    cr_first.quad = sq_dat[IdsSqrtSteps].quad;
    cr_first.mu   = sq_dat[IdsSqrtSteps].mu;
    cr_first.wt   = sq_dat[IdsSqrtSteps].root[15:0];
  end

  assign cr_vld[0] = sq_vld[IdsSqrtSteps];
  assign cr_dat[0] = cr_first;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    ids_cordic_cell #(.Stage(i)) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (adv),
      .vld_i (cr_vld[i]),
      .dat_i (cr_dat[i]),
      .vld_o (cr_vld[i+1]),
      .dat_o (cr_dat[i+1])
    );
  end

  // Quadrant restore and scaling by the sine weight.
  ids_cr_t            cr_last;
  logic signed [31:0] cs, sn;
  logic signed [16:0] wt_s;
  assign cr_last = cr_dat[CORDIC_STAGES];
  assign wt_s    = $signed({1'b0, cr_last.wt});

  always_comb begin
    case (cr_last.quad)
      2'd0:    begin cs = cr_last.x;  sn = cr_last.y;  end
      2'd1:    begin cs = -cr_last.y; sn = cr_last.x;  end
      2'd2:    begin cs = -cr_last.x; sn = -cr_last.y; end
      default: begin cs = cr_last.y;  sn = -cr_last.x; end
    endcase
  end

  logic               mul_vld_q;
  logic signed [48:0] px_q, py_q;
  logic signed [15:0] mu_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
    end else if (adv) begin
      mul_vld_q <= cr_vld[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      px_q <= cs * wt_s;
      py_q <= sn * wt_s;
      mu_q <= cr_last.mu;
    end
  end

  // Round to nearest with ties upward, then saturate to Q1.15.
  function automatic logic signed [15:0] round_sat(input logic signed [48:0] p);
    logic signed [48:0] r;
    logic signed [18:0] v;
    r = p + (49'sd1 <<< (IdsCordicFrac - 1));
    v = 19'(r >>> IdsCordicFrac);
    if (v > 19'sd32767) begin
      return 16'sh7FFF;
    end else if (v < -19'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  logic signed [15:0] dx_q, dy_q, dz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= mul_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx_q <= round_sat(px_q);
      dy_q <= round_sat(py_q);
      dz_q <= mu_q;
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.dir_x = dx_q;
  assign out_o.dir_y = dy_q;
  assign out_o.dir_z = dz_q;

endmodule

/* hdl/ids_checker.sv */
module ids_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] dir_x_i,
  input logic [15:0] dir_y_i,
  input logic [15:0] dir_z_i
);

  // A waiting result stays offered.
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // A waiting result keeps its x and y values.
  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(dir_x_i) && $stable(dir_y_i))
    else $error("result changed while stalled");

  // A polar cosine of minus one leaves no weight for x and y.
  a_pole: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && dir_z_i == 16'h8000 |-> dir_x_i == 16'h0 && dir_y_i == 16'h0)
    else $error("nonzero x or y at the south pole");

  // Nothing is offered right after reset.
  a_reset_empty: assert property (@(posedge clk_i)
    !$past(rst_ni) |-> !out_valid_i)
    else $error("result offered right after reset");

endmodule

bind isotropic_direction_sampler ids_checker u_ids_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .dir_x_i    (out_o.dir_x),
  .dir_y_i    (out_o.dir_y),
  .dir_z_i    (out_o.dir_z)
);
